[rtl/core/kmerge_pkg.sv]
package kmerge_pkg;

  // item mode codes
  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_PULL   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_UNUSED = 2'd3;

  // width of the lists-in-use register
  localparam int CfgW = 4;

  typedef struct packed {
    logic [1:0]         mode;
    logic [2:0]         list_number;
    logic signed [63:0] element;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] merged_value;
    logic [2:0]         source_list;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_APP  = 4'b0010,
    S_SCAN = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

endpackage

[rtl/core/kmerge_ram.sv]
module kmerge_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/kway_merge_of_sorted_lists.sv]
// flow: an append reads the list counts, then writes the value and counts or is refused
//   as full, then answers; an append to a list not in use, clear and spare mode go straight
//   to the answer; a pull scans the head of every list in use, then answers
// one item at a time, the next taken once the result is in the output register; a pull
//   is paced by the count memory read port, which examines one list head a cycle
// reset: asynchronous active low; all lists empty, lists in use 8 (MAX_LISTS if fewer), no result pending
module kway_merge_of_sorted_lists #(
  parameter int MAX_LISTS  = 8,
  parameter int LIST_DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  kmerge_pkg::in_item_t            in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output kmerge_pkg::out_item_t           out_data_o,
  input  logic                            cfg_we_i,
  input  logic [kmerge_pkg::CfgW-1:0]     cfg_wdata_i
);

  localparam int LW    = $clog2(MAX_LISTS);
  localparam int PW    = $clog2(LIST_DEPTH);
  localparam int CW    = $clog2(LIST_DEPTH + 1);
  localparam int DAW   = LW + PW;
  localparam int DDEP  = MAX_LISTS * (2 ** PW);
  localparam int RstLists = (MAX_LISTS < 8) ? MAX_LISTS : 8;
  localparam logic [LW-1:0] RST_LAST = LW'(RstLists - 1);
  localparam logic [LW-1:0] MAX_LAST = LW'(MAX_LISTS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(LIST_DEPTH);

  kmerge_pkg::state_e state_q, state_d;

  logic [LW-1:0]        last_q, last_d;
  logic [MAX_LISTS-1:0] vld_q, vld_d;

  logic                  out_valid_q, out_valid_d;
  kmerge_pkg::out_item_t out_q, out_d;
  kmerge_pkg::out_item_t res_q, res_d;

  logic signed [63:0] elem_q, elem_d;

  // scan pipeline
  logic [LW-1:0]      iss_idx_q, iss_idx_d;
  logic               iss_done_q, iss_done_d;
  logic               p1_v_q, p1_v_d;
  logic [LW-1:0]      p1_idx_q, p1_idx_d;
  logic               p2_v_q, p2_v_d;
  logic [LW-1:0]      p2_idx_q, p2_idx_d;
  logic [CW-1:0]      p2_wr_q, p2_wr_d;
  logic [CW-1:0]      p2_rd_q, p2_rd_d;
  logic               found_q, found_d;
  logic [LW-1:0]      best_idx_q, best_idx_d;
  logic [CW-1:0]      best_wr_q, best_wr_d;
  logic [CW-1:0]      best_rd_q, best_rd_d;
  logic signed [63:0] best_val_q, best_val_d;

  // memory ports
  logic            cnt_we;
  logic [LW-1:0]   cnt_waddr;
  logic [2*CW-1:0] cnt_wdata;
  logic [LW-1:0]   cnt_raddr;
  logic [2*CW-1:0] cnt_rdata;
  logic            dat_we;
  logic [DAW-1:0]  dat_waddr;
  logic [DAW-1:0]  dat_raddr;
  logic [63:0]     dat_rdata;

  logic [CW-1:0]   c_wr;
  logic [CW-1:0]   c_rd;

  // per-list append and pull counts
  kmerge_ram #(
    .WIDTH (2 * CW),
    .DEPTH (MAX_LISTS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  // list values, one region per list
  kmerge_ram #(
    .WIDTH (64),
    .DEPTH (DDEP)
  ) u_dat_ram (
    .clk_i   (clk_i),
    .we_i    (dat_we),
    .waddr_i (dat_waddr),
    .wdata_i (elem_q),
    .raddr_i (dat_raddr),
    .rdata_o (dat_rdata)
  );

  // counts of an entry never written since clear read as zero
  assign c_wr = vld_q[p1_idx_q] ? cnt_rdata[2*CW-1:CW] : '0;
  assign c_rd = vld_q[p1_idx_q] ? cnt_rdata[CW-1:0]    : '0;

  assign in_ready_o  = (state_q == kmerge_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // clamp lists in use to 1..MAX_LISTS, kept as index of the last list
  always_comb begin
    if (cfg_wdata_i == '0) begin
      last_d = '0;
    end else if (32'(cfg_wdata_i) > MAX_LISTS) begin
      last_d = MAX_LAST;
    end else begin
      last_d = LW'(cfg_wdata_i - 1'b1);
    end
  end

  // main control
  always_comb begin
    state_d     = state_q;
    vld_d       = vld_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    res_d       = res_q;
    elem_d      = elem_q;
    iss_idx_d   = iss_idx_q;
    iss_done_d  = iss_done_q;
    p1_v_d      = 1'b0;
    p1_idx_d    = p1_idx_q;
    p2_v_d      = 1'b0;
    p2_idx_d    = p1_idx_q;
    p2_wr_d     = c_wr;
    p2_rd_d     = c_rd;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_wr_d   = best_wr_q;
    best_rd_d   = best_rd_q;
    best_val_d  = best_val_q;
    cnt_we      = 1'b0;
    cnt_waddr   = p1_idx_q;
    cnt_wdata   = {c_wr + 1'b1, c_rd};
    cnt_raddr   = iss_idx_q;
    dat_we      = 1'b0;
    dat_waddr   = {p1_idx_q, c_wr[PW-1:0]};
    dat_raddr   = {p1_idx_q, c_rd[PW-1:0]};

    // output register drains independently
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      kmerge_pkg::S_IDLE: begin
        if (in_valid_i) begin
          res_d  = '0;
          elem_d = in_data_i.element;
          case (in_data_i.mode)
            kmerge_pkg::MODE_APPEND: begin
              if (32'(in_data_i.list_number) > 32'(last_q)) begin
                res_d.status = kmerge_pkg::ST_UNUSED;
                state_d      = kmerge_pkg::S_RESP;
              end else begin
                cnt_raddr = LW'(in_data_i.list_number);
                p1_idx_d  = LW'(in_data_i.list_number);
                state_d   = kmerge_pkg::S_APP;
              end
            end
            kmerge_pkg::MODE_PULL: begin
              cnt_raddr  = '0;
              p1_v_d     = 1'b1;
              p1_idx_d   = '0;
              iss_idx_d  = LW'(1);
              iss_done_d = (last_q == '0);
              found_d    = 1'b0;
              state_d    = kmerge_pkg::S_SCAN;
            end
            kmerge_pkg::MODE_CLEAR: begin
              vld_d   = '0;
              state_d = kmerge_pkg::S_RESP;
            end
            default: begin
              state_d = kmerge_pkg::S_RESP;
            end
          endcase
        end
      end

      kmerge_pkg::S_APP: begin
        if (c_wr == FULL_CNT) begin
          res_d.status = kmerge_pkg::ST_FULL;
        end else begin
          dat_we          = 1'b1;
          cnt_we          = 1'b1;
          vld_d[p1_idx_q] = 1'b1;
        end
        state_d = kmerge_pkg::S_RESP;
      end

      kmerge_pkg::S_SCAN: begin
        // issue the count read of the next list
        if (!iss_done_q) begin
          cnt_raddr  = iss_idx_q;
          p1_v_d     = 1'b1;
          p1_idx_d   = iss_idx_q;
          iss_idx_d  = iss_idx_q + 1'b1;
          iss_done_d = (iss_idx_q == last_q);
        end
        // counts back: read the head if the list is not exhausted
        p2_v_d = p1_v_q && (c_rd < c_wr);
        // head back: keep the smallest, first list wins ties
        if (p2_v_q && (!found_q || ($signed(dat_rdata) < best_val_q))) begin
          found_d    = 1'b1;
          best_idx_d = p2_idx_q;
          best_wr_d  = p2_wr_q;
          best_rd_d  = p2_rd_q;
          best_val_d = $signed(dat_rdata);
        end
        // all heads seen: advance the winner
        if (iss_done_q && !p1_v_q && !p2_v_q) begin
          if (found_q) begin
            cnt_we                = 1'b1;
            cnt_waddr             = best_idx_q;
            cnt_wdata             = {best_wr_q, best_rd_q + 1'b1};
            vld_d[best_idx_q]     = 1'b1;
            res_d.merged_value    = best_val_q;
            res_d.source_list     = 3'(best_idx_q);
            res_d.status          = kmerge_pkg::ST_OK;
          end else begin
            res_d.status = kmerge_pkg::ST_EMPTY;
          end
          state_d = kmerge_pkg::S_RESP;
        end
      end

      kmerge_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = kmerge_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = kmerge_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kmerge_pkg::S_IDLE;
      last_q      <= RST_LAST;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      iss_done_q  <= 1'b1;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
      iss_done_q  <= iss_done_d;
      p1_v_q      <= p1_v_d;
      p2_v_q      <= p2_v_d;
      found_q     <= found_d;
      if (cfg_we_i) begin
        last_q <= last_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    res_q      <= res_d;
    elem_q     <= elem_d;
    iss_idx_q  <= iss_idx_d;
    p1_idx_q   <= p1_idx_d;
    p2_idx_q   <= p2_idx_d;
    p2_wr_q    <= p2_wr_d;
    p2_rd_q    <= p2_rd_d;
    best_idx_q <= best_idx_d;
    best_wr_q  <= best_wr_d;
    best_rd_q  <= best_rd_d;
    best_val_q <= best_val_d;
  end

endmodule

[rtl/core/kmerge_check.sv]
module kmerge_check (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input kmerge_pkg::out_item_t out_data_o
);

  // one item in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted back to back");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // only a successful pull carries a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != kmerge_pkg::ST_OK)
      |-> (out_data_o.merged_value == '0) && (out_data_o.source_list == '0))
    else $error("value fields set on a non-ok result");

  // a result appears only after an item was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o || !$past(in_ready_o))
    else $error("result without an item");

endmodule

bind kway_merge_of_sorted_lists kmerge_check u_kmerge_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[verif/kmerge_result_checker.sv]
`timescale 1ns / 1ps

// watches both channels of the merge block, keeps its own copy of the lists
// and compares every result item against the oldest predicted one
module kmerge_result_checker #(
  parameter int MAX_LISTS  = 8,
  parameter int LIST_DEPTH = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  kmerge_pkg::in_item_t        in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  kmerge_pkg::out_item_t       out_data_i,
  input  logic                        cfg_we_i,
  input  logic [kmerge_pkg::CfgW-1:0] cfg_wdata_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  localparam int CntW = $clog2(LIST_DEPTH + 1);

  // shadow of the list memory and its pointers
  logic signed [63:0]          list_mem [MAX_LISTS][LIST_DEPTH];
  logic [CntW-1:0]             wr_cnt   [MAX_LISTS];
  logic [CntW-1:0]             rd_pos   [MAX_LISTS];
  logic [kmerge_pkg::CfgW-1:0] use_cnt;

  // merge answers still owed by the block, oldest first
  kmerge_pkg::out_item_t merge_answer_q [$];

  // apply one item to the shadow lists and return the answer it should get
  function automatic kmerge_pkg::out_item_t merge_step(kmerge_pkg::in_item_t item);
    kmerge_pkg::out_item_t res;
    int                    n;
    int                    best;
    bit                    found;
    logic signed [63:0]    best_val;
    logic signed [63:0]    head;
    res      = '0;
    res.status = kmerge_pkg::ST_OK;
    found    = 1'b0;
    best     = 0;
    best_val = '0;
    // a count of zero acts as one, anything past the list count as all lists
    n = (use_cnt == 0) ? 1 : ((use_cnt > MAX_LISTS) ? MAX_LISTS : int'(use_cnt));
    case (item.mode)
      kmerge_pkg::MODE_APPEND: begin
        if (int'(item.list_number) >= n) begin
          res.status = kmerge_pkg::ST_UNUSED;
        end else if (wr_cnt[item.list_number] >= LIST_DEPTH) begin
          // full counts appends since clear, pulls do not free room
          res.status = kmerge_pkg::ST_FULL;
        end else begin
          list_mem[item.list_number][wr_cnt[item.list_number]] = item.element;
          wr_cnt[item.list_number]++;
        end
      end
      kmerge_pkg::MODE_PULL: begin
        // strict less-than keeps ties on the lowest list
        for (int i = 0; i < n; i++) begin
          if (rd_pos[i] < wr_cnt[i]) begin
            head = list_mem[i][rd_pos[i]];
            if (!found || head < best_val) begin
              found    = 1'b1;
              best     = i;
              best_val = head;
            end
          end
        end
        if (found) begin
          rd_pos[best]++;
          res.merged_value = best_val;
          res.source_list  = best[2:0];
        end else begin
          res.status = kmerge_pkg::ST_EMPTY;
        end
      end
      kmerge_pkg::MODE_CLEAR: begin
        for (int i = 0; i < MAX_LISTS; i++) begin
          wr_cnt[i] = '0;
          rd_pos[i] = '0;
        end
      end
      default: begin
        // spare mode leaves everything as it was
      end
    endcase
    return res;
  endfunction

  // sample both channels on the rising edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    kmerge_pkg::out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LISTS; i++) begin
        wr_cnt[i] = '0;
        rd_pos[i] = '0;
      end
      use_cnt = kmerge_pkg::CfgW'(8);
      merge_answer_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) use_cnt = cfg_wdata_i;
      if (in_valid_i && in_ready_i)
        merge_answer_q.insert(merge_answer_q.size(), merge_step(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (merge_answer_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 20)
            $display("%0t: unexpected item value %0d list %0d status %0d", $time,
                     out_data_i.merged_value, out_data_i.source_list, out_data_i.status);
        end else begin
          want = merge_answer_q.pop_front();
          if (out_data_i.merged_value !== want.merged_value ||
              out_data_i.source_list !== want.source_list ||
              out_data_i.status !== want.status) begin
            fail_count_o++;
            if (fail_count_o <= 20)
              $display({"%0t: mismatch expected value %0d list %0d status %0d,",
                        " got value %0d list %0d status %0d"},
                       $time, want.merged_value, want.source_list, want.status,
                       out_data_i.merged_value, out_data_i.source_list, out_data_i.status);
          end
        end
      end
      pending_o = merge_answer_q.size();
    end
  end

endmodule

[verif/kway_merge_of_sorted_lists_tb.sv]
`timescale 1ns / 1ps

module kway_merge_of_sorted_lists_tb;

  localparam int MaxLists   = 8;
  localparam int ListDepth  = 256;
  localparam int ItemTarget = 1450;
  localparam int HoldStart  = 4000;
  localparam int HoldLen    = 500;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  kmerge_pkg::in_item_t        in_data   = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  kmerge_pkg::out_item_t       out_data;
  logic                        cfg_we    = 1'b0;
  logic [kmerge_pkg::CfgW-1:0] cfg_wdata = '0;
  int                          fail_count;
  int                          pending;

  // stimulus bookkeeping
  int                 items_sent = 0;
  int                 use_now    = MaxLists;
  logic signed [63:0] tail_val [MaxLists];

  always #6 clk = ~clk;

  kway_merge_of_sorted_lists #(
    .MAX_LISTS  (MaxLists),
    .LIST_DEPTH (ListDepth)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  kmerge_result_checker #(
    .MAX_LISTS  (MaxLists),
    .LIST_DEPTH (ListDepth)
  ) u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // mostly back to back, sometimes a few cycles, rarely a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // next value of an ascending run; small steps make ties likely
  function automatic logic signed [63:0] next_sorted(int ln);
    if ($urandom_range(0, 19) == 0) tail_val[ln] = tail_val[ln] + rand64();
    else tail_val[ln] = tail_val[ln] + $urandom_range(0, 6);
    return tail_val[ln];
  endfunction

  // offer one item and hold it until the block takes it
  task automatic drive_item(input logic [1:0] md, input logic [2:0] ln,
                            input logic signed [63:0] el, input bit calm);
    int gap;
    gap = calm ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = '{mode: md, list_number: ln, element: el};
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // register write once every owed answer is back
  task automatic write_lists_in_use(input logic [kmerge_pkg::CfgW-1:0] v);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we  = 1'b0;
    use_now = (v == 0) ? 1 : ((v > MaxLists) ? MaxLists : int'(v));
  endtask

  // an optional clear, then one burst of appends with some pulls and spare items mixed in, then drain the lists
  task automatic merge_phase(input int n_app, input bit do_clear, input bit calm);
    logic signed [63:0] base;
    int                 r;
    int                 ln;
    if (do_clear)
      drive_item(kmerge_pkg::MODE_CLEAR, 3'($urandom_range(0, 7)), rand64(), calm);
    r = $urandom_range(0, 9);
    if (r == 0) base = {1'b1, 63'd0};
    else if (r == 1) base = 64'sh7FFF_FFFF_FFFF_FF00;
    else base = rand64();
    for (int l = 0; l < MaxLists; l++) tail_val[l] = base + $urandom_range(0, 20);
    for (int i = 0; i < n_app; i++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 4) == 0) ln = $urandom_range(0, MaxLists - 1);
      else ln = $urandom_range(0, use_now - 1);
      if (r < 8)
        drive_item(kmerge_pkg::MODE_APPEND, 3'(ln), rand64(), calm);
      else if (r < 11)
        drive_item(kmerge_pkg::MODE_SPARE, 3'($urandom_range(0, 7)), rand64(), calm);
      else if (r < 30)
        drive_item(kmerge_pkg::MODE_PULL, 3'($urandom_range(0, 7)), rand64(), calm);
      else
        drive_item(kmerge_pkg::MODE_APPEND, 3'(ln), next_sorted(ln), calm);
    end
    for (int i = 0; i < n_app + 2; i++)
      drive_item(kmerge_pkg::MODE_PULL, 3'($urandom_range(0, 7)), rand64(), calm);
  endtask

  // receiver: random stalls, calm stretches, one long hold-off
  initial begin : rx_side
    int cyc;
    int stall_left;
    bit calm;
    cyc        = 0;
    stall_left = 0;
    calm       = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 250 == 0) calm = ($urandom_range(0, 3) == 0);
      if (cyc >= HoldStart && cyc < HoldStart + HoldLen) begin
        out_ready = 1'b0;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if (!calm && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  // sender and verdict
  initial begin : tx_side
    logic [kmerge_pkg::CfgW-1:0] cfg_plan [11];
    int                          phase;
    int                          ln;
    cfg_plan = '{4'd3, 4'd1, 4'd0, 4'd15, 4'd8, 4'd5, 4'd2, 4'd9, 4'd6, 4'd4, 4'd7};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty pull, field extremes, ties, spare mode, drain, clear
    drive_item(kmerge_pkg::MODE_PULL, 3'd0, '0, 1'b0);
    drive_item(kmerge_pkg::MODE_APPEND, 3'd0, {1'b1, 63'd0}, 1'b0);
    drive_item(kmerge_pkg::MODE_APPEND, 3'd0, {1'b0, {63{1'b1}}}, 1'b0);
    drive_item(kmerge_pkg::MODE_APPEND, 3'd7, '0, 1'b0);
    drive_item(kmerge_pkg::MODE_APPEND, 3'd3, {1'b1, 63'd0}, 1'b0);
    drive_item(kmerge_pkg::MODE_APPEND, 3'd3, -64'sd1, 1'b0);
    drive_item(kmerge_pkg::MODE_APPEND, 3'd1, 64'sd5, 1'b0);
    drive_item(kmerge_pkg::MODE_APPEND, 3'd2, 64'sd5, 1'b0);
    drive_item(kmerge_pkg::MODE_SPARE, 3'd7, '1, 1'b0);
    repeat (8) drive_item(kmerge_pkg::MODE_PULL, 3'd7, '1, 1'b0);
    drive_item(kmerge_pkg::MODE_CLEAR, 3'd5, '1, 1'b0);
    // fewer lists in use: append beyond them is refused
    write_lists_in_use(4'd2);
    drive_item(kmerge_pkg::MODE_APPEND, 3'd5, 64'sd17, 1'b0);
    drive_item(kmerge_pkg::MODE_APPEND, 3'd1, 64'sd42, 1'b0);
    drive_item(kmerge_pkg::MODE_PULL, 3'd0, '0, 1'b0);

    // random phases; one of them fills a list past its depth
    phase = 0;
    while (items_sent < ItemTarget) begin
      if (phase == 4) begin
        write_lists_in_use(4'd8);
        drive_item(kmerge_pkg::MODE_CLEAR, 3'd0, '0, 1'b0);
        ln = $urandom_range(0, MaxLists - 1);
        tail_val[ln] = rand64();
        for (int i = 0; i < ListDepth + 4; i++) begin
          drive_item(kmerge_pkg::MODE_APPEND, 3'(ln), next_sorted(ln), 1'b0);
          if (i % 32 == 31) drive_item(kmerge_pkg::MODE_PULL, 3'd0, '0, 1'b0);
        end
        repeat (6) drive_item(kmerge_pkg::MODE_PULL, 3'd0, '0, 1'b0);
      end else begin
        if (phase % 2 == 0) write_lists_in_use(cfg_plan[(phase / 2) % 11]);
        merge_phase($urandom_range(10, 40), $urandom_range(0, 3) != 0,
                    $urandom_range(0, 3) == 0);
      end
      phase++;
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
